// ----- rtl/gelu_pkg.sv -----
package gelu_pkg;

    // Fixed widths of the sample path.
    localparam int SAMPLE_W     = 16;
    localparam int GATE_W       = 16;
    localparam int FRAC_W       = 15;
    localparam int MAG_W        = 15;
    localparam int GATE_Q_W     = 31;
    localparam int SEGMENTS_DEF = 64;

    // Range limits of the table, in raw Q4.12 units.
    localparam logic signed [SAMPLE_W-1:0] X_LOW  = -16'sd16384;
    localparam logic signed [SAMPLE_W-1:0] X_HIGH = 16'sd16384;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MODE = 1'b0;

    // Gate forms.
    localparam logic MODE_ERF  = 1'b0;
    localparam logic MODE_TANH = 1'b1;

    // Constants of the table generator, Q.40.
    localparam int          QFRAC      = 40;
    localparam logic [63:0] ONE_Q      = 64'd1 << QFRAC;
    localparam logic [63:0] K_SQRT2_PI = 64'd877283352226;
    localparam logic [63:0] K_CUBIC    = 64'd49164662436;
    localparam int          ERF_TERMS  = 48;
    localparam int          HYP_TERMS  = 24;

    // Side information that travels down the pipeline with each sample.
    typedef struct packed {
        logic                       valid;
        logic                       below;
        logic                       above;
        logic signed [SAMPLE_W-1:0] sample;
    } t_side;

    // Product of two Q.40 values, truncated back to Q.40.
    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[103:40];
    endfunction

    // Unsigned quotient by shift and subtract, for the table generator.
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Gate 0.5*(1+erf(x/sqrt2)) in Q0.16 for a nonnegative Q.40 magnitude.
    function automatic logic [GATE_W-1:0] erf_gate(input logic [63:0] xm);
        logic [63:0]        h;
        logic [63:0]        term;
        logic [63:0]        q;
        logic [63:0]        e;
        logic [63:0]        g;
        logic signed [63:0] acc;
        int                 n;
        h    = mulq(xm, xm) >> 1;
        term = ONE_Q;
        acc  = '0;
        for (n = 0; n < ERF_TERMS; n++) begin
            q = udiv(term, 64'(2 * n + 1));
            if (n[0]) begin
                acc = acc - $signed(q);
            end else begin
                acc = acc + $signed(q);
            end
            term = udiv(mulq(term, h), 64'(n + 1));
        end
        if (acc < 0) begin
            acc = '0;
        end
        e = mulq(mulq(K_SQRT2_PI, xm), 64'(acc));
        if (e > ONE_Q) begin
            e = ONE_Q;
        end
        g = (ONE_Q + e + (64'd1 << 24)) >> 25;
        return (g > 64'd65535) ? 16'hFFFF : g[GATE_W-1:0];
    endfunction

    // Gate of the tanh form in Q0.16, built from cosh and sinh series.
    function automatic logic [GATE_W-1:0] tanh_gate(input logic [63:0] xm);
        logic [63:0] x3;
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] ch;
        logic [63:0] sh;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] g;
        int          n;
        x3 = mulq(mulq(xm, xm), xm);
        u  = mulq(K_SQRT2_PI, xm + mulq(K_CUBIC, x3));
        t  = ONE_Q;
        ch = '0;
        sh = '0;
        for (n = 0; n < HYP_TERMS; n++) begin
            ch = ch + t;
            t  = udiv(mulq(t, u), 64'(2 * n + 1));
            sh = sh + t;
            t  = udiv(mulq(t, u), 64'(2 * n + 2));
        end
        num = (ch + sh) >> 8;
        den = ch >> 8;
        g   = udiv({num[47:0], 16'd0} + den, {den[62:0], 1'b0});
        return (g > 64'd65535) ? 16'hFFFF : g[GATE_W-1:0];
    endfunction

    // Breakpoint k of the gate table, at x = -4 + 8k/Segments.
    function automatic logic [GATE_W-1:0] gate_entry(input logic sel, input int k,
                                                     input int Segments);
        int          d;
        int          mag;
        logic [63:0] xm;
        logic [16:0] g;
        d   = 8 * k - 4 * Segments;
        mag = (d < 0) ? -d : d;
        xm  = udiv(64'(mag) << QFRAC, 64'(Segments));
        g   = {1'b0, ((sel == MODE_TANH) ? tanh_gate(xm) : erf_gate(xm))};
        if (d < 0) begin
            g = 17'd65536 - g;
        end
        return g[GATE_W-1:0];
    endfunction

endpackage

// ----- rtl/gelu_lookup.sv -----
module gelu_lookup
    import gelu_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_mode,
    output t_side                      o_side,
    output logic [GATE_W-1:0]          o_gate_a,
    output logic [GATE_W-1:0]          o_gate_b,
    output logic [FRAC_W-1:0]          o_frac
);

    localparam int SEG_W  = $clog2(SEGMENTS);
    localparam int ROM_AW = $clog2(SEGMENTS + 1);
    localparam int POS_W  = FRAC_W + SEG_W;

    // Gate breakpoints for both forms, fixed at elaboration.
    logic [GATE_W-1:0] w_rom_erf  [SEGMENTS+1];
    logic [GATE_W-1:0] w_rom_tanh [SEGMENTS+1];

    for (genvar gk = 0; gk <= SEGMENTS; gk++) begin : g_rom
        localparam logic [GATE_W-1:0] ErfG  = gate_entry(MODE_ERF, gk, SEGMENTS);
        localparam logic [GATE_W-1:0] TanhG = gate_entry(MODE_TANH, gk, SEGMENTS);
        assign w_rom_erf[gk]  = ErfG;
        assign w_rom_tanh[gk] = TanhG;
    end

    // Stage 1: position within the table, split into segment and fraction.
    t_side             n_s1_side;
    logic [FRAC_W-1:0] w_offset;
    logic [POS_W-1:0]  w_pos;
    t_side             r_s1_side;
    logic [SEG_W-1:0]  r_s1_seg;
    logic [FRAC_W-1:0] r_s1_frac;
    logic              r_s1_mode;

    always_comb begin
        w_offset         = FRAC_W'(i_sample + X_HIGH);
        w_pos            = POS_W'(w_offset) * POS_W'(SEGMENTS);
        n_s1_side.valid  = i_valid;
        n_s1_side.below  = (i_sample < X_LOW);
        n_s1_side.above  = (i_sample >= X_HIGH);
        n_s1_side.sample = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_side <= n_s1_side;
            r_s1_seg  <= w_pos[POS_W-1:FRAC_W];
            r_s1_frac <= w_pos[FRAC_W-1:0];
            r_s1_mode <= i_mode;
        end
    end

    // Stage 2: registered read of the two breakpoints around the sample.
    logic [ROM_AW-1:0] w_idx_a;
    logic [ROM_AW-1:0] w_idx_b;
    t_side             r_s2_side;
    logic [GATE_W-1:0] r_s2_a;
    logic [GATE_W-1:0] r_s2_b;
    logic [FRAC_W-1:0] r_s2_frac;

    assign w_idx_a = ROM_AW'(r_s1_seg);
    assign w_idx_b = w_idx_a + ROM_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side.valid <= 1'b0;
        end else if (i_en) begin
            r_s2_side <= r_s1_side;
            r_s2_frac <= r_s1_frac;
            if (r_s1_mode == MODE_TANH) begin
                r_s2_a <= w_rom_tanh[w_idx_a];
                r_s2_b <= w_rom_tanh[w_idx_b];
            end else begin
                r_s2_a <= w_rom_erf[w_idx_a];
                r_s2_b <= w_rom_erf[w_idx_b];
            end
        end
    end

    assign o_side   = r_s2_side;
    assign o_gate_a = r_s2_a;
    assign o_gate_b = r_s2_b;
    assign o_frac   = r_s2_frac;

endmodule

// ----- rtl/gelu_product.sv -----
module gelu_product
    import gelu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_side                      i_side,
    input  logic [GATE_W-1:0]          i_gate_a,
    input  logic [GATE_W-1:0]          i_gate_b,
    input  logic [FRAC_W-1:0]          i_frac,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    // Stage 3: linear interpolation of the gate and the sample magnitude.
    logic signed [GATE_W:0]     w_diff;
    logic signed [GATE_W+16:0]  w_slope;
    logic signed [GATE_W+16:0]  w_gate;
    logic [SAMPLE_W-1:0]        w_mag;
    t_side                      r_s3_side;
    logic [GATE_Q_W-1:0]        r_s3_gate;
    logic [MAG_W-1:0]           r_s3_mag;

    always_comb begin
        w_diff  = $signed({1'b0, i_gate_b}) - $signed({1'b0, i_gate_a});
        w_slope = (GATE_W + 17)'(w_diff) * $signed({18'd0, i_frac});
        w_gate  = $signed({2'b00, i_gate_a, 15'd0}) + w_slope;
        w_mag   = i_side.sample[SAMPLE_W-1] ? SAMPLE_W'(-i_side.sample)
                                            : SAMPLE_W'(i_side.sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_side.valid <= 1'b0;
        end else if (i_en) begin
            r_s3_side <= i_side;
            r_s3_gate <= w_gate[GATE_Q_W-1:0];
            r_s3_mag  <= w_mag[MAG_W-1:0];
        end
    end

    // Stage 4: scale, round half away from zero, apply sign and clamp.
    logic [MAG_W+GATE_Q_W:0]     w_prod;
    logic [SAMPLE_W-1:0]         w_round;
    logic signed [SAMPLE_W-1:0]  n_sample;
    logic                        r_valid;
    logic signed [SAMPLE_W-1:0]  r_sample;

    always_comb begin
        w_prod  = (MAG_W + GATE_Q_W + 1)'(r_s3_mag) * (MAG_W + GATE_Q_W + 1)'(r_s3_gate)
                + ((MAG_W + GATE_Q_W + 1)'(1) << 30);
        w_round = w_prod[MAG_W+GATE_Q_W:31];
        if (r_s3_side.below) begin
            n_sample = '0;
        end else if (r_s3_side.above) begin
            n_sample = r_s3_side.sample;
        end else if (r_s3_side.sample[SAMPLE_W-1]) begin
            n_sample = (w_round > 16'd32768) ? -16'sd32768 : $signed(-w_round);
        end else begin
            n_sample = (w_round > 16'd32767) ? 16'sd32767 : $signed(w_round);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= r_s3_side.valid;
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

// ----- rtl/gelu_activation_unit.sv -----
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------
// input    | in        | i_in_valid / o_in_ready   | i_sample_in  (Q4.12)
// output   | out       | o_out_valid / i_out_ready | o_sample_out (Q4.12)
// config   | in        | APB psel/penable/pready   | mode at address 0
//
// One sample per cycle is accepted while the output is not stalled; a result
// is offered from the last of the four pipeline registers (index,
// table read, interpolation, scale and clamp). A stall at the output freezes
// the whole pipeline, so o_in_ready follows !o_out_valid || i_out_ready.
// Synchronous active-low reset clears the valid bits and the mode register;
// the gate table is constant and needs no fill.
module gelu_activation_unit
    import gelu_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    // Mode register and its read-back.
    logic r_mode;
    logic w_sel_mode;

    assign w_sel_mode = (paddr[2] == REG_MODE);
    assign pready     = 1'b1;
    assign prdata     = w_sel_mode ? {{(PDATA_W-1){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ERF;
        end else if (psel && penable && pwrite && pready && w_sel_mode) begin
            r_mode <= pwdata[0];
        end
    end

    // The pipeline advances whenever the output register can move.
    logic              w_en;
    t_side             w_side;
    logic [GATE_W-1:0] w_gate_a;
    logic [GATE_W-1:0] w_gate_b;
    logic [FRAC_W-1:0] w_frac;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    gelu_lookup #(
        .SEGMENTS (SEGMENTS)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_sample (i_sample_in),
        .i_mode   (r_mode),
        .o_side   (w_side),
        .o_gate_a (w_gate_a),
        .o_gate_b (w_gate_b),
        .o_frac   (w_frac)
    );

    gelu_product u_product (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_side   (w_side),
        .i_gate_a (w_gate_a),
        .i_gate_b (w_gate_b),
        .i_frac   (w_frac),
        .o_valid  (o_out_valid),
        .o_sample (o_sample_out)
    );

endmodule

// ----- rtl/gelu_checker.sv -----
module gelu_checker
    import gelu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_in_ready,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SAMPLE_W-1:0] o_sample_out
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample_out))
        else $error("result changed while stalled");

    // A full, stalled pipeline takes no new transaction.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // GELU never goes far below zero.
    a_min_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_out >= -16'sd1024))
        else $error("result below the GELU minimum");

endmodule

bind gelu_activation_unit gelu_checker u_gelu_checker (.*);

// ----- tb/tb_gelu_activation_unit.sv -----
module tb_gelu_activation_unit;
    import gelu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_profile;

    localparam int                 SEGS          = SEGMENTS_DEF;
    localparam logic [PADDR_W-1:0] ADDR_MODE     = PADDR_W'(4 * int'(REG_MODE));
    localparam logic [PADDR_W-1:0] ADDR_SPARE    = PADDR_W'(4);
    localparam int                 SETTLE_CYCLES = 8;
    localparam int                 HOLD_CYCLES   = 300;
    localparam int                 CYCLE_LIMIT   = 200000;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_in  = '0;
    logic                       i_out_ready  = 1'b0;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [PADDR_W-1:0]         paddr        = '0;
    logic [PDATA_W-1:0]         pwdata       = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // Gate breakpoints per form, Q0.16, and the shadow of the mode register.
    int   gate_tab [2][SEGS+1];
    logic mode_shadow = MODE_ERF;

    // Results still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] gelu_expect_q [$];

    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          tx_gap_max    = 0;
    int          burst_left    = 0;
    t_rx_profile rx_profile    = RX_FREE;
    int          rx_stall_pct  = 0;
    int          rx_phase      = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;

    gelu_activation_unit #(
        .SEGMENTS(SEGS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample_out(o_sample_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Q.40 product, truncated back to Q.40.
    function automatic t_u64 qmul(input t_u64 a, input t_u64 b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return t_u64'(full >> QFRAC);
    endfunction

    // Half of one plus erf(x/sqrt2), Q0.16, for a nonnegative Q.40 magnitude.
    function automatic int erf_half_gate(input t_u64 xm);
        t_u64   half_sq;
        t_u64   term;
        t_u64   q;
        t_u64   e;
        t_u64   g;
        longint acc;
        int     n;
        half_sq = qmul(xm, xm) >> 1;
        term    = ONE_Q;
        acc     = 0;
        for (n = 0; n < ERF_TERMS; n++) begin
            q = term / t_u64'(2 * n + 1);
            if (n % 2 == 1) begin
                acc = acc - longint'(q);
            end else begin
                acc = acc + longint'(q);
            end
            term = qmul(term, half_sq) / t_u64'(n + 1);
        end
        if (acc < 0) begin
            acc = 0;
        end
        e = qmul(qmul(K_SQRT2_PI, xm), t_u64'(acc));
        if (e > ONE_Q) begin
            e = ONE_Q;
        end
        g = (t_u64'(ONE_Q) + e + (t_u64'(1) << 24)) >> 25;
        return (g > 65535) ? 65535 : int'(g);
    endfunction

    // Tanh form of the gate, Q0.16, from cosh and sinh power series.
    function automatic int tanh_half_gate(input t_u64 xm);
        t_u64 cube;
        t_u64 arg;
        t_u64 t;
        t_u64 cosh_sum;
        t_u64 sinh_sum;
        t_u64 num;
        t_u64 den;
        t_u64 g;
        int   n;
        cube     = qmul(qmul(xm, xm), xm);
        arg      = qmul(K_SQRT2_PI, xm + qmul(K_CUBIC, cube));
        t        = ONE_Q;
        cosh_sum = 0;
        sinh_sum = 0;
        for (n = 0; n < HYP_TERMS; n++) begin
            cosh_sum = cosh_sum + t;
            t        = qmul(t, arg) / t_u64'(2 * n + 1);
            sinh_sum = sinh_sum + t;
            t        = qmul(t, arg) / t_u64'(2 * n + 2);
        end
        num = (cosh_sum + sinh_sum) >> 8;
        den = cosh_sum >> 8;
        g   = (num * 65536 + den) / (2 * den);
        return (g > 65535) ? 65535 : int'(g);
    endfunction

    // Fill both gate tables; negative breakpoints mirror around one half.
    function automatic void build_gate_tab();
        int   sel;
        int   k;
        int   d;
        int   g;
        t_u64 xm;
        for (sel = 0; sel < 2; sel++) begin
            for (k = 0; k <= SEGS; k++) begin
                d  = 8 * k - 4 * SEGS;
                xm = (t_u64'((d < 0) ? -d : d) << QFRAC) / t_u64'(SEGS);
                g  = (sel == int'(MODE_TANH)) ? tanh_half_gate(xm) : erf_half_gate(xm);
                gate_tab[sel][k] = (d < 0) ? 65536 - g : g;
            end
        end
    endfunction

    // GELU of one sample: interpolated gate, rounded product, clamped.
    function automatic logic signed [SAMPLE_W-1:0] gelu_of(
        input logic signed [SAMPLE_W-1:0] x,
        input logic                       sel
    );
        int     v;
        int     pos;
        int     seg;
        longint w;
        longint lo;
        longint hi;
        longint gate;
        longint mag;
        longint r;
        v = int'(x);
        if (x < X_LOW) begin
            return '0;
        end
        if (x >= X_HIGH) begin
            return x;
        end
        pos  = (v + 16384) * SEGS;
        seg  = pos >>> 15;
        w    = longint'(pos & 32767);
        lo   = longint'(gate_tab[sel][seg]);
        hi   = longint'(gate_tab[sel][seg+1]);
        gate = lo * 32768 + (hi - lo) * w;
        if (gate < 0) begin
            gate = 0;
        end
        mag = (v < 0) ? -longint'(v) : longint'(v);
        r   = (mag * gate + (longint'(1) << 30)) >>> 31;
        if (v < 0) begin
            return (r > 32768) ? -16'sd32768 : SAMPLE_W'(-r);
        end
        return (r > 32767) ? 16'sd32767 : SAMPLE_W'(r);
    endfunction

    // Mostly inside the table, some near its edges, some anywhere.
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return SAMPLE_W'($urandom());
        end
        if (pick == 1) begin
            return SAMPLE_W'(($urandom_range(1) ? 16384 : -16384)
                             + int'($urandom_range(16)) - 8);
        end
        return SAMPLE_W'(int'($urandom_range(32767)) - 16384);
    endfunction

    // Receiver: a long hold-off on request, otherwise the current stall pattern.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            rx_phase = (rx_phase + 1) % 7;
            case (rx_profile)
                RX_FREE: begin
                    i_out_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    i_out_ready <= (int'($urandom_range(99)) >= rx_stall_pct);
                end
                default: begin
                    i_out_ready <= (rx_phase >= 3);
                end
            endcase
        end
    end

    // Output monitor: every output transaction is matched with the oldest expectation.
    always @(negedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gelu_expect_q.size() == 0) begin
                $error("sample_out: transaction with nothing expected, actual %0d",
                       o_sample_out);
                mismatches++;
            end else begin
                want = gelu_expect_q.pop_front();
                if (o_sample_out !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, o_sample_out);
                    mismatches++;
                end
            end
        end
    end

    // Offer one sample and return at the edge that accepts it. The valid is
    // left high so that back-to-back samples need only one assignment.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(negedge i_clk); while (!o_in_ready);
        gelu_expect_q.push_back(gelu_of(x, mode_shadow));
        @(posedge i_clk);
    endtask

    // Stop offering and wait until every owed result is out and the pipe is empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (gelu_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        data = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change the gate form once the block is idle; upper data bits are junk.
    task automatic set_gate_form(input logic sel);
        logic [PDATA_W-1:0] junk;
        junk = $urandom();
        drain();
        apb_write(ADDR_MODE, {junk[PDATA_W-1:1], sel});
        mode_shadow = sel;
    endtask

    task automatic check_mode_readback();
        logic [PDATA_W-1:0] rd;
        apb_read(ADDR_MODE, rd);
        if (rd !== PDATA_W'(mode_shadow)) begin
            $error("mode: expected %0d, actual %0d", mode_shadow, rd);
            mismatches++;
        end
    endtask

    // Reset value, both forms, upper bits dropped, and a write to no register.
    task automatic test_register_access();
        check_mode_readback();
        apb_write(ADDR_MODE, 32'hFFFF_FFFF);
        mode_shadow = MODE_TANH;
        check_mode_readback();
        apb_write(ADDR_MODE, 32'hFFFF_FFFE);
        mode_shadow = MODE_ERF;
        check_mode_readback();
        apb_write(ADDR_MODE, 32'h0000_0001);
        mode_shadow = MODE_TANH;
        apb_write(ADDR_SPARE, 32'hAAAA_AAAA);
        check_mode_readback();
        apb_write(ADDR_SPARE, 32'h5555_5554);
        check_mode_readback();
        repeat (4) send_sample(random_sample());
        drain();
    endtask

    // Field extremes, both sides of the table edges, and the zero crossing.
    task automatic test_directed_edges();
        logic signed [SAMPLE_W-1:0] picks [12];
        int                         sel;
        int                         i;
        picks = '{-16'sd32768, 16'sd32767, -16'sd16385, -16'sd16384, 16'sd16383,
                  16'sd16384, 16'sd0, 16'sd1, -16'sd1, 16'sd512, -16'sd12345, 16'sd4095};
        tx_gap_max = 0;
        rx_profile = RX_FREE;
        for (sel = 0; sel < 2; sel++) begin
            set_gate_form(sel[0]);
            for (i = 0; i < 12; i++) begin
                send_sample(picks[i]);
            end
        end
        drain();
    endtask

    // Random traffic under several idling profiles, alternating gate forms.
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            set_gate_form(phase[0] ? MODE_TANH : MODE_ERF);
            case (phase % 4)
                0: begin
                    rx_profile = RX_FREE;
                    tx_gap_max = 0;
                end
                1: begin
                    rx_profile   = RX_RANDOM;
                    rx_stall_pct = 30;
                    tx_gap_max   = 3;
                end
                2: begin
                    rx_profile = RX_PERIODIC;
                    tx_gap_max = 6;
                end
                default: begin
                    rx_profile   = RX_RANDOM;
                    rx_stall_pct = 70;
                    tx_gap_max   = 1;
                end
            endcase
            repeat (65) send_sample(random_sample());
        end
        drain();
    endtask

    // Long receiver hold-off while the sender keeps pushing, so input stalls.
    task automatic test_output_hold_off();
        set_gate_form(1'($urandom_range(1)));
        rx_profile    = RX_RANDOM;
        rx_stall_pct  = 20;
        tx_gap_max    = 0;
        hold_requests = hold_requests + 1;
        repeat (40) send_sample(random_sample());
        drain();
    endtask

    // Sender pauses until all results are back, then resumes.
    task automatic test_pause_and_resume();
        rx_profile   = RX_RANDOM;
        rx_stall_pct = 40;
        tx_gap_max   = 2;
        repeat (10) send_sample(random_sample());
        drain();
        repeat (10) send_sample(random_sample());
        drain();
    endtask

    initial begin
        build_gate_tab();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_edges();
        test_random_traffic();
        test_output_hold_off();
        test_pause_and_resume();

        drain();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
